@@ rtl/core/tset_pkg.sv @@
// ----------------------------------------------------------------------------
// tset_pkg: shared types and constants of the time sorted event table
// Entry and request types, table sizing and status codes.
// ----------------------------------------------------------------------------
package tset_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int TIME_W   = 32;
	localparam int VALUE_W  = 32;
	localparam int KIND_W   = 8;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DELETE = 1'b1;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	// one stored mark
	typedef struct packed {
		logic [TIME_W-1:0]  etime;
		logic [VALUE_W-1:0] evalue;
		logic [KIND_W-1:0]  ekind;
	} entry_t;

	// request broadcast to every cell
	typedef struct packed {
		logic               ins;
		logic               del;
		logic [TIME_W-1:0]  key_time;
		logic [KIND_W-1:0]  key_kind;
		logic [VALUE_W-1:0] value;
	} op_t;

endpackage

@@ rtl/core/tset_cell.sv @@
// ----------------------------------------------------------------------------
// tset_cell: one slot of the sorted table
// Compares its mark with the broadcast request and shifts toward a
// neighbor on insert (right) or delete (left).
// ----------------------------------------------------------------------------
module tset_cell
	import tset_pkg::*;
(
	input  logic   clk,
	input  op_t    op,
	input  logic   valid,
	input  entry_t left_entry,
	input  entry_t right_entry,
	input  logic   left_before,
	output logic   earlier,
	input  logic   left_seen,
	output logic   seen,
	output entry_t entry
);

	entry_t entry_q;
	logic   match;

	// compare against the request key
	assign earlier = valid && (entry_q.etime < op.key_time);
	assign match   = valid && (entry_q.etime == op.key_time) && (entry_q.ekind == op.key_kind);
	assign seen    = left_seen | match;
	assign entry   = entry_q;

	// load new mark, shift right on insert, shift left on delete
	always_ff @(posedge clk) begin
		if (op.ins && !earlier) begin
			if (left_before) begin
				entry_q.etime  <= op.key_time;
				entry_q.evalue <= op.value;
				entry_q.ekind  <= op.key_kind;
			end else begin
				entry_q <= left_entry;
			end
		end else if (op.del && seen) begin
			entry_q <= right_entry;
		end
	end

endmodule

@@ rtl/core/time_sorted_event_table.sv @@
// ----------------------------------------------------------------------------
// time_sorted_event_table: table of marks kept in ascending time order
// A request is registered first; then all cells compare in parallel and shift
// along the chain, and the result is strobed.
// ----------------------------------------------------------------------------
// done is registered from busy, which is set by the edge that accepts start.
// A new request is taken only while busy is low, so it waits for the register stage
//   in front of the cell chain and the compare and shift that follows to finish.
// The receiver cannot stall; each result is valid for the one done cycle.
// Reset (arst_n low) empties the table at once; cell contents are not reset.
module time_sorted_event_table
	import tset_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [KIND_W-1:0]  mark_type,
	input  logic [VALUE_W-1:0] sign_value,
	input  logic [TIME_W-1:0]  sign_time,
	output logic               done,
	output logic [1:0]         status,
	output logic               found,
	output logic [4:0]         entry_count
);

	logic               busy_q;
	logic               func_q;
	logic [KIND_W-1:0]  kind_q;
	logic [VALUE_W-1:0] value_q;
	logic [TIME_W-1:0]  time_q;
	logic [CNT_W-1:0]   count_q;
	logic               done_q;
	logic [1:0]         status_q;
	logic               found_q;

	op_t    op;
	logic   ins_ok;
	logic   del_ok;
	entry_t cell_entry [CAPACITY];
	logic   cell_before [CAPACITY];
	logic   cell_seen [CAPACITY];
	logic   cell_valid [CAPACITY];
	logic   hit;
	logic [CNT_W+4:0] count_ext;

	// capture the request
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			func_q  <= func;
			kind_q  <= mark_type;
			value_q <= sign_value;
			time_q  <= sign_time;
		end
	end

	// decide which edit is allowed
	assign ins_ok = busy_q && (func_q == FUNC_INSERT) && (kind_q != '0)
		&& (count_q < CNT_W'(CAPACITY));
	assign del_ok = busy_q && (func_q == FUNC_DELETE) && (count_q != '0);

	assign op.ins      = ins_ok;
	assign op.del      = del_ok;
	assign op.key_time = time_q;
	assign op.key_kind = kind_q;
	assign op.value    = value_q;

	// chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_b;
		logic   left_s;

		assign cell_valid[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_e = cell_entry[i];
			assign left_b = 1'b1;
			assign left_s = 1'b0;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_b = cell_before[i-1];
			assign left_s = cell_seen[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_e = cell_entry[i];
		end else begin : g_inner
			assign right_e = cell_entry[i+1];
		end

		tset_cell u_cell (
			.clk         (clk),
			.op          (op),
			.valid       (cell_valid[i]),
			.left_entry  (left_e),
			.right_entry (right_e),
			.left_before (left_b),
			.earlier     (cell_before[i]),
			.left_seen   (left_s),
			.seen        (cell_seen[i]),
			.entry       (cell_entry[i])
		);
	end

	assign hit = cell_seen[CAPACITY-1];

	// sequence the request, update the count, strobe the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= '0;
			status_q <= ST_DONE;
			found_q  <= 1'b0;
		end else begin
			done_q <= busy_q;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q  <= 1'b0;
				found_q <= 1'b0;
				if (func_q == FUNC_INSERT) begin
					if (kind_q == '0) begin
						status_q <= ST_REJECT;
					end else if (!ins_ok) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_DONE;
						count_q  <= count_q + CNT_W'(1);
					end
				end else begin
					if (!del_ok) begin
						status_q <= ST_REJECT;
					end else begin
						status_q <= ST_DONE;
						found_q  <= hit;
						if (hit) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
				end
			end
		end
	end

	assign count_ext   = {5'b0, count_q};
	assign busy        = busy_q;
	assign done        = done_q;
	assign status      = status_q;
	assign found       = found_q;
	assign entry_count = count_ext[4:0];

	// checks
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("done without a request in progress");

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q)
		else $error("request held longer than one cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && found_q) |-> (status_q == ST_DONE && $past(func_q) == FUNC_DELETE))
		else $error("found set on a request that removed nothing");

	a_reject_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != ST_DONE) |-> (count_q == $past(count_q)))
		else $error("count changed on a refused request");

endmodule

@@ verif/tb_time_sorted_event_table.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_time_sorted_event_table: self-checking bench for the time sorted table
// A clocked driver issues insert and delete requests from a queue built at
// time zero. A table predictor in the bench computes the status, found flag
// and entry count of every accepted request. A clocked monitor compares each
// strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_time_sorted_event_table;
	import tset_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_REQS  = 1100;
	localparam int KEY_HISTORY  = 32;

	typedef struct {
		logic               func;
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic [TIME_W-1:0]  stamp;
		bit                 hold;
		int                 gap;
	} request_t;

	typedef struct packed {
		logic [1:0] status;
		logic       found;
		logic [4:0] count;
	} outcome_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [TIME_W-1:0] stamp;
	} mark_key_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               start       = 1'b0;
	logic               func        = FUNC_INSERT;
	logic [KIND_W-1:0]  mark_type   = '0;
	logic [VALUE_W-1:0] sign_value  = '0;
	logic [TIME_W-1:0]  sign_time   = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic               found;
	logic [4:0]         entry_count;

	request_t  pending_requests[$];
	outcome_t  expected_outcomes[$];
	mark_key_t inserted_keys[$];

	// table predictor state
	logic [TIME_W-1:0]  mark_time[CAPACITY];
	logic [VALUE_W-1:0] mark_value[CAPACITY];
	logic [KIND_W-1:0]  mark_kind[CAPACITY];
	int                 mark_count = 0;

	request_t cur_req;
	int       gap_left   = 0;
	bit       fire;
	outcome_t got;
	outcome_t want;
	int       mismatches = 0;
	int       cycles     = 0;

	time_sorted_event_table i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.mark_type   (mark_type),
		.sign_value  (sign_value),
		.sign_time   (sign_time),
		.done        (done),
		.status      (status),
		.found       (found),
		.entry_count (entry_count)
	);

	always #1 clk = ~clk;

	// apply one request to the predicted table and return its outcome
	function automatic outcome_t table_apply(request_t r);
		int       pos;
		bit       hit;
		outcome_t o;
		o.status = ST_DONE;
		o.found  = 1'b0;
		if (r.func == FUNC_INSERT) begin
			if (r.kind == '0) begin
				o.status = ST_REJECT;
			end else if (mark_count >= CAPACITY) begin
				o.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < mark_count && mark_time[pos] < r.stamp)
					pos++;
				for (int i = mark_count; i > pos; i--) begin
					mark_time[i]  = mark_time[i-1];
					mark_value[i] = mark_value[i-1];
					mark_kind[i]  = mark_kind[i-1];
				end
				mark_time[pos]  = r.stamp;
				mark_value[pos] = r.value;
				mark_kind[pos]  = r.kind;
				mark_count++;
			end
		end else if (mark_count == 0) begin
			o.status = ST_REJECT;
		end else begin
			hit = 1'b0;
			for (pos = 0; pos < mark_count && !hit; pos++) begin
				if (mark_time[pos] == r.stamp && mark_kind[pos] == r.kind)
					hit = 1'b1;
			end
			if (hit) begin
				// pos ran one past the matching slot
				for (int i = pos - 1; i + 1 < mark_count; i++) begin
					mark_time[i]  = mark_time[i+1];
					mark_value[i] = mark_value[i+1];
					mark_kind[i]  = mark_kind[i+1];
				end
				mark_count--;
				o.found = 1'b1;
			end
		end
		o.count = 5'(mark_count);
		return o;
	endfunction

	task automatic add_request(logic f, logic [KIND_W-1:0] k, logic [VALUE_W-1:0] v,
			logic [TIME_W-1:0] t, bit hold, int gap);
		request_t r;
		r.func  = f;
		r.kind  = k;
		r.value = v;
		r.stamp = t;
		r.hold  = hold;
		r.gap   = gap;
		pending_requests.push_back(r);
		if (f == FUNC_INSERT && k != '0) begin
			mark_key_t key;
			key.kind  = k;
			key.stamp = t;
			inserted_keys.push_back(key);
			if (inserted_keys.size() > KEY_HISTORY)
				void'(inserted_keys.pop_front());
		end
	endtask

	// build the directed requests, then the random traffic
	task automatic build_requests();
		int               ins_pct;
		bit               burst;
		int               sel;
		int               idx;
		logic [KIND_W-1:0] k;
		logic [TIME_W-1:0] t;
		ins_pct = 50;
		burst   = 1'b0;
		// delete on an empty table, insert with type zero
		add_request(FUNC_DELETE, 8'd1, 32'd0, 32'd0, 1'b0, 0);
		add_request(FUNC_INSERT, 8'd0, 32'hFFFF_FFFF, 32'd5, 1'b0, $urandom_range(0, 4));
		// fill the table: extreme times, values and types, equal times
		add_request(FUNC_INSERT, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0);
		add_request(FUNC_INSERT, 8'd1, 32'd0, 32'd0, 1'b0, $urandom_range(0, 4));
		for (int i = 2; i < CAPACITY; i++)
			add_request(FUNC_INSERT, 8'(i), $urandom, 32'((i % 3) * 100), 1'b0,
				$urandom_range(0, 4));
		// insert into a full table; type zero is checked before fullness
		add_request(FUNC_INSERT, 8'd5, $urandom, 32'd7, 1'b0, 0);
		add_request(FUNC_INSERT, 8'd0, $urandom, 32'd7, 1'b0, 0);
		// delete with no match, then matches with the value ignored
		add_request(FUNC_DELETE, 8'd7, $urandom, 32'd12345, 1'b0, 1);
		add_request(FUNC_DELETE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0);
		add_request(FUNC_DELETE, 8'd1, 32'd0, 32'd0, 1'b0, 2);
		add_request(FUNC_DELETE, 8'd4, $urandom, 32'd100, 1'b0, 0);

		for (int n = 0; n < RANDOM_REQS; n++) begin
			// change the insert bias and the pacing every fifty requests
			if (n % 50 == 0) begin
				case ($urandom_range(0, 3))
					0: ins_pct = 15;
					1: ins_pct = 50;
					2: ins_pct = 85;
					default: ins_pct = 97;
				endcase
				burst = ($urandom_range(0, 3) == 0);
			end
			sel = $urandom_range(0, 99);
			if (sel < 5)
				k = '0;
			else if (sel < 65)
				k = 8'($urandom_range(1, 3));
			else
				k = 8'($urandom_range(0, 255));
			sel = $urandom_range(0, 99);
			if (sel < 55)
				t = 32'($urandom_range(0, 7));
			else
				t = $urandom;
			if ($urandom_range(0, 99) < ins_pct) begin
				add_request(FUNC_INSERT, k, $urandom, t, (n == 0) || ($urandom_range(0, 149) == 0),
					burst ? 0 : $urandom_range(0, 4));
			end else begin
				// mostly delete a key that was inserted earlier
				if (inserted_keys.size() != 0 && $urandom_range(0, 99) < 75) begin
					idx = $urandom_range(0, inserted_keys.size() - 1);
					k   = inserted_keys[idx].kind;
					t   = inserted_keys[idx].stamp;
					inserted_keys.delete(idx);
				end
				add_request(FUNC_DELETE, k, $urandom, t, (n == 0) || ($urandom_range(0, 149) == 0),
					burst ? 0 : $urandom_range(0, 4));
			end
		end
	endtask

	// drive requests; predict each one on the edge that accepts it
	always @(posedge clk) begin
		if (arst_n) begin
			fire = start;
			if (start && !busy) begin
				expected_outcomes.push_back(table_apply(cur_req));
				fire     = 1'b0;
				gap_left = (pending_requests.size() != 0) ? pending_requests[0].gap : 0;
			end
			if (!fire) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_requests.size() != 0 &&
						(!pending_requests[0].hold || expected_outcomes.size() == 0)) begin
					cur_req    = pending_requests.pop_front();
					func       <= cur_req.func;
					mark_type  <= cur_req.kind;
					sign_value <= cur_req.value;
					sign_time  <= cur_req.stamp;
					fire       = 1'b1;
				end
			end
			start <= fire;
		end
	end

	// check each strobed result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			got = {status, found, entry_count};
			if (expected_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d found %0d count %0d",
						status, found, entry_count);
			end else begin
				want = expected_outcomes.pop_front();
				if (got.status !== want.status || got.found !== want.found ||
						got.count !== want.count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: status %0d/%0d found %0d/%0d count %0d/%0d (exp/act)",
							want.status, got.status, want.found, got.found,
							want.count, got.count);
				end
			end
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		build_requests();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_requests.size() != 0 || start)
			@(posedge clk);
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		// let any stray strobe show up
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_outcomes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
